@@ rtl/cmto_pkg.sv @@
// Shared types and constants of the colour marker tracker with overlay.
`default_nettype none

package cmto_pkg;

  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CNT_W       = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RED_LOW       = 3'd0,
    CFG_RED_HIGH      = 3'd1,
    CFG_DIM_LIMIT     = 3'd2,
    CFG_BLUE_LOW      = 3'd3,
    CFG_BLUE_HIGH     = 3'd4,
    CFG_HIT_THRESHOLD = 3'd5,
    CFG_BOX_SIZE      = 3'd6,
    CFG_TRACK_WINDOW  = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] red_low;
    logic [CFG_DATA_W-1:0] red_high;
    logic [CFG_DATA_W-1:0] dim_limit;
    logic [CFG_DATA_W-1:0] blue_low;
    logic [CFG_DATA_W-1:0] blue_high;
    logic [CNT_W-1:0]      hit_threshold;
    logic [CFG_DATA_W-1:0] box_size;
    logic [CFG_DATA_W-1:0] track_window;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    red_low:       10'd640,
    red_high:      10'd1020,
    dim_limit:     10'd400,
    blue_low:      10'd360,
    blue_high:     10'd880,
    hit_threshold: 4'd6,
    box_size:      10'd40,
    track_window:  10'd10
  };

  // Per-pixel classification handed from the blur stage to the tracker.
  typedef struct packed {
    logic red_hit;
    logic blue_hit;
    logic run_start;
    logic frame_start;
    logic line_black;
  } flags_t;

  localparam logic [4:0]  RUN_LEN = 5'd15;

  localparam logic [15:0] LINE_Y0 = 16'd0;
  localparam logic [15:0] LINE_Y1 = 16'd145;
  localparam logic [15:0] LINE_Y2 = 16'd265;
  localparam logic [15:0] LINE_Y3 = 16'd385;
  localparam logic [15:0] LINE_Y4 = 16'd505;

  // Volume is (480 - y) / 90; the quotient uses a reciprocal that is exact below 2**19 / 52.
  localparam logic [15:0]      VOL_TOP      = 16'd480;
  localparam logic [12:0]      VOL_RECIP    = 13'd5826;
  localparam int               VOL_SHIFT    = 19;
  localparam logic signed [4:0] VOL_MAX_STEP = 5'sd2;

endpackage

`default_nettype wire

@@ rtl/cmto_in_if.sv @@
// Input channel: one column of three stacked pixels and the pixel position.
`default_nettype none

interface cmto_in_if #(
  parameter int COLOUR_BITS = 10,
  parameter int COORD_BITS  = 10
);
  logic                     valid;
  logic                     ready;
  logic [3*COLOUR_BITS-1:0] top_pixel;
  logic [3*COLOUR_BITS-1:0] middle_pixel;
  logic [3*COLOUR_BITS-1:0] bottom_pixel;
  logic [COORD_BITS-1:0]    x_coord;
  logic [COORD_BITS-1:0]    y_coord;

  modport source (
    output valid, top_pixel, middle_pixel, bottom_pixel, x_coord, y_coord,
    input  ready
  );

  modport sink (
    input  valid, top_pixel, middle_pixel, bottom_pixel, x_coord, y_coord,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/cmto_out_if.sv @@
// Result channel: the overlaid pixel and the held volume level.
`default_nettype none

interface cmto_out_if #(
  parameter int COLOUR_BITS = 10
);
  logic                     valid;
  logic                     ready;
  logic [3*COLOUR_BITS-1:0] pixel_out;
  logic [3:0]               volume_level;

  modport source (
    output valid, pixel_out, volume_level,
    input  ready
  );

  modport sink (
    input  valid, pixel_out, volume_level,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/cmto_blur.sv @@
// Input register, column window, 3x3 blur and per-pixel marker classification.
`default_nettype none

module cmto_blur #(
  parameter int COLOUR_BITS = 10,
  parameter int COORD_BITS  = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmto_pkg::cfg_t           cfg,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [3*COLOUR_BITS-1:0] top_pixel,
  input  wire logic [3*COLOUR_BITS-1:0] middle_pixel,
  input  wire logic [3*COLOUR_BITS-1:0] bottom_pixel,
  input  wire logic [COORD_BITS-1:0]    x_coord,
  input  wire logic [COORD_BITS-1:0]    y_coord,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [3*COLOUR_BITS-1:0]      pixel,
  output logic [COORD_BITS-1:0]         x,
  output logic [COORD_BITS-1:0]         y,
  output cmto_pkg::flags_t              flags
);

  localparam int PW  = 3 * COLOUR_BITS;
  localparam int SW  = COLOUR_BITS + 4;
  localparam int TW  = (COLOUR_BITS > cmto_pkg::CFG_DATA_W) ? COLOUR_BITS
                                                            : cmto_pkg::CFG_DATA_W;
  localparam int NIB = (COORD_BITS + 3) / 4;

  logic                   valid;
  logic [PW-1:0]          col_new [3];
  logic [PW-1:0]          col_one [3];
  logic [PW-1:0]          col_two [3];
  logic [COORD_BITS-1:0]  x_reg;
  logic [COORD_BITS-1:0]  y_reg;
  logic                   load;

  logic [SW-1:0]          sum [3];
  logic [COLOUR_BITS-1:0] blur [3];
  logic [TW-1:0]          red_e, green_e, blue_e;
  logic [4*NIB-1:0]       x_pad;
  logic [7:0]             nib_sum;
  logic [4:0]             nib_fold;
  logic [15:0]            y_wide;

  assign in_ready  = !valid || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid;

  // The window shifts only when a new word is taken, so a held word keeps its neighbors.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        col_new[r] <= '0;
        col_one[r] <= '0;
        col_two[r] <= '0;
      end
    end else if (load) begin
      valid      <= 1'b1;
      col_two    <= col_one;
      col_one    <= col_new;
      col_new[0] <= top_pixel;
      col_new[1] <= middle_pixel;
      col_new[2] <= bottom_pixel;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_reg <= x_coord;
      y_reg <= y_coord;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SW'(col_new[0][c*COLOUR_BITS +: COLOUR_BITS])
             + (SW'(col_new[1][c*COLOUR_BITS +: COLOUR_BITS]) << 1)
             + SW'(col_new[2][c*COLOUR_BITS +: COLOUR_BITS])
             + ((SW'(col_one[0][c*COLOUR_BITS +: COLOUR_BITS])
               + (SW'(col_one[1][c*COLOUR_BITS +: COLOUR_BITS]) << 1)
               + SW'(col_one[2][c*COLOUR_BITS +: COLOUR_BITS])) << 1)
             + SW'(col_two[0][c*COLOUR_BITS +: COLOUR_BITS])
             + (SW'(col_two[1][c*COLOUR_BITS +: COLOUR_BITS]) << 1)
             + SW'(col_two[2][c*COLOUR_BITS +: COLOUR_BITS]);
      blur[c] = sum[c][SW-1:4];
    end
  end

  assign red_e   = TW'(blur[2]);
  assign green_e = TW'(blur[1]);
  assign blue_e  = TW'(blur[0]);

  // Since 16 is one more than 15, x mod 15 follows from the sum of its hex digits.
  assign x_pad = (4*NIB)'(x_reg);
  always_comb begin
    nib_sum = '0;
    for (int n = 0; n < NIB; n++) begin
      nib_sum = nib_sum + 8'(x_pad[4*n +: 4]);
    end
  end
  assign nib_fold = 5'(nib_sum[7:4]) + 5'(nib_sum[3:0]);
  assign y_wide   = 16'(y_reg);

  assign flags.red_hit = (red_e >= TW'(cfg.red_low)) && (red_e <= TW'(cfg.red_high)) &&
                         (green_e <= TW'(cfg.dim_limit)) && (blue_e <= TW'(cfg.dim_limit));
  assign flags.blue_hit = (red_e <= TW'(cfg.dim_limit)) && (green_e <= TW'(cfg.dim_limit)) &&
                          (blue_e >= TW'(cfg.blue_low)) && (blue_e <= TW'(cfg.blue_high));
  assign flags.run_start   = (nib_fold == 5'd0) || (nib_fold == cmto_pkg::RUN_LEN);
  assign flags.frame_start = (x_reg == '0) && (y_reg == '0);
  assign flags.line_black  = (y_wide == cmto_pkg::LINE_Y0) || (y_wide == cmto_pkg::LINE_Y1) ||
                             (y_wide == cmto_pkg::LINE_Y2) || (y_wide == cmto_pkg::LINE_Y3) ||
                             (y_wide == cmto_pkg::LINE_Y4);

  assign pixel = {blur[2], blur[1], blur[0]};
  assign x     = x_reg;
  assign y     = y_reg;

endmodule

`default_nettype wire

@@ rtl/cmto_tracker.sv @@
// Hit counters, first-hit latches and windowed position trackers for both markers.
`default_nettype none

module cmto_tracker #(
  parameter int COLOUR_BITS = 10,
  parameter int COORD_BITS  = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmto_pkg::cfg_t           cfg,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [3*COLOUR_BITS-1:0] in_pixel,
  input  wire logic [COORD_BITS-1:0]    in_x,
  input  wire logic [COORD_BITS-1:0]    in_y,
  input  wire cmto_pkg::flags_t         in_flags,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [3*COLOUR_BITS-1:0]      pixel,
  output logic [COORD_BITS-1:0]         x,
  output logic [COORD_BITS-1:0]         y,
  output logic                          line_black,
  output logic [COORD_BITS-1:0]         red_x,
  output logic [COORD_BITS-1:0]         red_y,
  output logic [COORD_BITS-1:0]         blue_x,
  output logic [COORD_BITS-1:0]         blue_y
);

  localparam int CW = COORD_BITS;
  localparam int AW = (COORD_BITS > cmto_pkg::CFG_DATA_W) ? COORD_BITS
                                                          : cmto_pkg::CFG_DATA_W;

  logic                         valid;
  logic [3*COLOUR_BITS-1:0]     pixel_reg;
  logic [CW-1:0]                x_reg;
  logic [CW-1:0]                y_reg;
  cmto_pkg::flags_t             flags_reg;
  logic                         load;
  logic                         commit;

  logic [cmto_pkg::CNT_W-1:0]   red_cnt, blue_cnt;
  logic [cmto_pkg::CNT_W-1:0]   red_cnt_next, blue_cnt_next;
  logic [CW-1:0]                found_rx, found_ry, found_bx, found_by;
  logic [CW-1:0]                base_rx, base_ry, base_bx, base_by;
  logic [CW-1:0]                found_rx_next, found_ry_next, found_bx_next, found_by_next;
  logic [CW-1:0]                track_rx, track_ry, track_bx, track_by;
  logic [2*CW-1:0]              red_follow, blue_follow;
  logic                         red_latch, blue_latch;

  // Restart from the latch when not yet tracking, then follow if either axis is close.
  function automatic logic [2*CW-1:0] follow(input logic [CW-1:0] tx,
                                             input logic [CW-1:0] ty,
                                             input logic [CW-1:0] fx,
                                             input logic [CW-1:0] fy,
                                             input logic [cmto_pkg::CFG_DATA_W-1:0] win);
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] adx;
    logic [CW-1:0] ady;
    logic          near;
    sx = tx;
    sy = ty;
    if (tx == '0 && fx != '0) begin
      sx = fx;
      sy = fy;
    end
    adx  = (fx >= sx) ? fx - sx : sx - fx;
    ady  = (fy >= sy) ? fy - sy : sy - fy;
    near = (AW'(ady) < AW'(win)) || (AW'(adx) < AW'(win));
    return near ? {fx, fy} : {sx, sy};
  endfunction

  assign in_ready  = !valid || out_ready;
  assign load      = in_valid && in_ready;
  assign commit    = valid && out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_reg <= in_pixel;
      x_reg     <= in_x;
      y_reg     <= in_y;
      flags_reg <= in_flags;
    end
  end

  always_comb begin
    red_cnt_next  = flags_reg.run_start ? '0 : red_cnt;
    blue_cnt_next = flags_reg.run_start ? '0 : blue_cnt;
    red_cnt_next  = red_cnt_next + cmto_pkg::CNT_W'(flags_reg.red_hit);
    blue_cnt_next = blue_cnt_next + cmto_pkg::CNT_W'(flags_reg.blue_hit);
  end

  assign base_rx = flags_reg.frame_start ? '0 : found_rx;
  assign base_ry = flags_reg.frame_start ? '0 : found_ry;
  assign base_bx = flags_reg.frame_start ? '0 : found_bx;
  assign base_by = flags_reg.frame_start ? '0 : found_by;

  assign red_latch  = (red_cnt_next > cfg.hit_threshold) && base_rx == '0 && base_ry == '0;
  assign blue_latch = (blue_cnt_next > cfg.hit_threshold) && base_bx == '0 && base_by == '0;

  assign found_rx_next = red_latch  ? x_reg : base_rx;
  assign found_ry_next = red_latch  ? y_reg : base_ry;
  assign found_bx_next = blue_latch ? x_reg : base_bx;
  assign found_by_next = blue_latch ? y_reg : base_by;

  assign red_follow  = follow(track_rx, track_ry, found_rx_next, found_ry_next,
                              cfg.track_window);
  assign blue_follow = follow(track_bx, track_by, found_bx_next, found_by_next,
                              cfg.track_window);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_cnt  <= '0;
      blue_cnt <= '0;
      found_rx <= '0;
      found_ry <= '0;
      found_bx <= '0;
      found_by <= '0;
      track_rx <= '0;
      track_ry <= '0;
      track_bx <= '0;
      track_by <= '0;
    end else if (commit) begin
      red_cnt  <= red_cnt_next;
      blue_cnt <= blue_cnt_next;
      found_rx <= found_rx_next;
      found_ry <= found_ry_next;
      found_bx <= found_bx_next;
      found_by <= found_by_next;
      {track_rx, track_ry} <= red_follow;
      {track_bx, track_by} <= blue_follow;
    end
  end

  assign pixel          = pixel_reg;
  assign x              = x_reg;
  assign y              = y_reg;
  assign line_black     = flags_reg.line_black;
  assign {red_x, red_y}   = red_follow;
  assign {blue_x, blue_y} = blue_follow;

endmodule

`default_nettype wire

@@ rtl/cmto_overlay.sv @@
// Box overlay, line blanking, volume tracking and the result register.
`default_nettype none

module cmto_overlay #(
  parameter int COLOUR_BITS = 10,
  parameter int COORD_BITS  = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmto_pkg::cfg_t           cfg,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [3*COLOUR_BITS-1:0] in_pixel,
  input  wire logic [COORD_BITS-1:0]    in_x,
  input  wire logic [COORD_BITS-1:0]    in_y,
  input  wire logic                     in_line_black,
  input  wire logic [COORD_BITS-1:0]    in_red_x,
  input  wire logic [COORD_BITS-1:0]    in_red_y,
  input  wire logic [COORD_BITS-1:0]    in_blue_x,
  input  wire logic [COORD_BITS-1:0]    in_blue_y,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [3*COLOUR_BITS-1:0]      pixel_out,
  output logic [3:0]                    volume_level
);

  localparam int CW = COORD_BITS;
  localparam int AW = (COORD_BITS > cmto_pkg::CFG_DATA_W) ? COORD_BITS
                                                          : cmto_pkg::CFG_DATA_W;
  localparam int NW = (COORD_BITS > 9) ? COORD_BITS : 9;
  localparam int MW = NW + 13;

  logic                     valid;
  logic [3*COLOUR_BITS-1:0] pixel_reg;
  logic [CW-1:0]            x_reg, y_reg;
  logic                     black_reg;
  logic [CW-1:0]            red_x, red_y, blue_x, blue_y;
  logic                     load;
  logic                     advance;
  logic                     stage_ready;

  logic                     in_red_box, in_blue_box;
  logic [3*COLOUR_BITS-1:0] pixel_next;
  logic [NW-1:0]            ty, n;
  logic                     neg;
  logic [MW-1:0]            prod;
  logic [3:0]               vmag, vcur;
  logic signed [4:0]        vdiff;
  logic [3:0]               held, held_next;

  function automatic logic inside_box(input logic [CW-1:0] px,
                                      input logic [CW-1:0] py,
                                      input logic [CW-1:0] bx,
                                      input logic [CW-1:0] by,
                                      input logic [cmto_pkg::CFG_DATA_W-1:0] size);
    return (px >= bx) && (AW'(px - bx) <= AW'(size)) &&
           (py >= by) && (AW'(py - by) <= AW'(size));
  endfunction

  assign stage_ready = !out_valid || out_ready;
  assign in_ready    = !valid || stage_ready;
  assign load        = in_valid && in_ready;
  assign advance     = valid && stage_ready;

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_reg <= in_pixel;
      x_reg     <= in_x;
      y_reg     <= in_y;
      black_reg <= in_line_black;
      red_x     <= in_red_x;
      red_y     <= in_red_y;
      blue_x    <= in_blue_x;
      blue_y    <= in_blue_y;
    end
  end

  assign in_red_box  = inside_box(x_reg, y_reg, red_x, red_y, cfg.box_size);
  assign in_blue_box = inside_box(x_reg, y_reg, blue_x, blue_y, cfg.box_size);

  always_comb begin
    pixel_next = pixel_reg;
    if (in_red_box) begin
      pixel_next = {{COLOUR_BITS{1'b1}}, {(2*COLOUR_BITS){1'b0}}};
    end
    if (in_blue_box) begin
      pixel_next = {{(2*COLOUR_BITS){1'b0}}, {COLOUR_BITS{1'b1}}};
    end
    if (black_reg) begin
      pixel_next = '0;
    end
  end

  // The quotient is truncated toward zero, so a y below the top mark gives a wrapped negative.
  assign ty    = NW'(red_y);
  assign neg   = ty > NW'(cmto_pkg::VOL_TOP);
  assign n     = neg ? ty - NW'(cmto_pkg::VOL_TOP) : NW'(cmto_pkg::VOL_TOP) - ty;
  assign prod  = MW'(n) * MW'(cmto_pkg::VOL_RECIP);
  assign vmag  = 4'(prod >> cmto_pkg::VOL_SHIFT);
  assign vcur  = neg ? 4'(4'd0 - vmag) : vmag;
  assign vdiff = $signed({1'b0, vcur}) - $signed({1'b0, held});
  assign held_next = (vdiff >= -cmto_pkg::VOL_MAX_STEP && vdiff <= cmto_pkg::VOL_MAX_STEP)
                     ? vcur : held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      out_valid <= 1'b0;
      held      <= '0;
    end else begin
      if (load) begin
        valid <= 1'b1;
      end else if (stage_ready) begin
        valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        held      <= held_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_out    <= pixel_next;
      volume_level <= (red_y == '0) ? 4'd0 : held_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/colour_marker_tracker_overlay.sv @@
// Top level of the colour marker tracker with box overlay and volume output.
//
// The pixel channel takes one word per cycle unless stalled: a column of three
// stacked pixels and the screen position of the bottom one. The result channel
// returns one word per input word, in order: the blurred pixel with the marker
// boxes and the blanked lines drawn in, and the held volume level.
// The block is a four-register pipeline: input register and blur, tracker,
// overlay, result register. A word accepted at the input passes through the
// blur, tracker, overlay and result registers in turn, and one word per cycle is
// sustained when nothing stalls. The tracker state closes its loop within a
// single stage, which is what allows a new word in every cycle.
// Each stage holds its word until the next stage has room, so bubbles are
// squeezed out and the input keeps accepting while a result waits; only when all
// four registers are full and the receiver stalls does the input stop.
// Reset empties the pipeline, clears the column window, hit counts, latched and
// tracked positions and volume, and loads the default thresholds. Configuration
// registers must be written by the user via the write port while idle; unchecked.
`default_nettype none

module colour_marker_tracker_overlay #(
  parameter int COLOUR_BITS = 10,
  parameter int COORD_BITS  = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [cmto_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [cmto_pkg::CFG_DATA_W-1:0]      cfg_data,
  cmto_in_if.sink                                   pix,
  cmto_out_if.source                                res
);

  localparam int PW = 3 * COLOUR_BITS;

  cmto_pkg::cfg_t   cfg;

  logic             blur_valid, blur_ready;
  logic [PW-1:0]    blur_pixel;
  logic [COORD_BITS-1:0] blur_x, blur_y;
  cmto_pkg::flags_t blur_flags;

  logic             trk_valid, trk_ready;
  logic [PW-1:0]    trk_pixel;
  logic [COORD_BITS-1:0] trk_x, trk_y;
  logic             trk_black;
  logic [COORD_BITS-1:0] trk_red_x, trk_red_y, trk_blue_x, trk_blue_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= cmto_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cmto_pkg::cfg_index_t'(cfg_index))
        cmto_pkg::CFG_RED_LOW:       cfg.red_low       <= cfg_data;
        cmto_pkg::CFG_RED_HIGH:      cfg.red_high      <= cfg_data;
        cmto_pkg::CFG_DIM_LIMIT:     cfg.dim_limit     <= cfg_data;
        cmto_pkg::CFG_BLUE_LOW:      cfg.blue_low      <= cfg_data;
        cmto_pkg::CFG_BLUE_HIGH:     cfg.blue_high     <= cfg_data;
        cmto_pkg::CFG_HIT_THRESHOLD: cfg.hit_threshold <= cfg_data[cmto_pkg::CNT_W-1:0];
        cmto_pkg::CFG_BOX_SIZE:      cfg.box_size      <= cfg_data;
        cmto_pkg::CFG_TRACK_WINDOW:  cfg.track_window  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cmto_blur #(
    .COLOUR_BITS (COLOUR_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_blur (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (pix.valid),
    .in_ready     (pix.ready),
    .top_pixel    (pix.top_pixel),
    .middle_pixel (pix.middle_pixel),
    .bottom_pixel (pix.bottom_pixel),
    .x_coord      (pix.x_coord),
    .y_coord      (pix.y_coord),
    .out_valid    (blur_valid),
    .out_ready    (blur_ready),
    .pixel        (blur_pixel),
    .x            (blur_x),
    .y            (blur_y),
    .flags        (blur_flags)
  );

  cmto_tracker #(
    .COLOUR_BITS (COLOUR_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (blur_valid),
    .in_ready   (blur_ready),
    .in_pixel   (blur_pixel),
    .in_x       (blur_x),
    .in_y       (blur_y),
    .in_flags   (blur_flags),
    .out_valid  (trk_valid),
    .out_ready  (trk_ready),
    .pixel      (trk_pixel),
    .x          (trk_x),
    .y          (trk_y),
    .line_black (trk_black),
    .red_x      (trk_red_x),
    .red_y      (trk_red_y),
    .blue_x     (trk_blue_x),
    .blue_y     (trk_blue_y)
  );

  cmto_overlay #(
    .COLOUR_BITS (COLOUR_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_overlay (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (trk_valid),
    .in_ready      (trk_ready),
    .in_pixel      (trk_pixel),
    .in_x          (trk_x),
    .in_y          (trk_y),
    .in_line_black (trk_black),
    .in_red_x      (trk_red_x),
    .in_red_y      (trk_red_y),
    .in_blue_x     (trk_blue_x),
    .in_blue_y     (trk_blue_y),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .pixel_out     (res.pixel_out),
    .volume_level  (res.volume_level)
  );

endmodule

`default_nettype wire

@@ rtl/cmto_checker.sv @@
// Port-level checks of the marker tracker pipeline, bound to the top level.
`default_nettype none

module cmto_checker #(
  parameter int COLOUR_BITS = 10
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [3*COLOUR_BITS-1:0] pixel_out,
  input wire logic [3:0]               volume_level
);

  // After reset the pipeline is empty and takes words at once.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty and ready after reset");

  // The input only stops while a result waits and the receiver stalls.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the result side can move");

  // A stalled result word holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(volume_level))
    else $error("result word changed while stalled");

  // After reset no result appears before a word has passed all four registers.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid [*4])
    else $error("result appeared sooner than the pipeline depth");

endmodule

bind colour_marker_tracker_overlay cmto_checker #(
  .COLOUR_BITS (COLOUR_BITS)
) u_cmto_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (pix.ready),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .pixel_out    (res.pixel_out),
  .volume_level (res.volume_level)
);

`default_nettype wire
